[rtl/core/phg_pkg.sv]
// Shared types and constants for the PES header generator.
// Holds the request and output byte structs and the header queue entry type.
// No dependencies.
package phg_pkg;

    // One header request as it arrives on the input channel.
    typedef struct packed {
        logic [23:0] body_len;
        logic [7:0]  stream_code;
        logic        pts_valid;
        logic [32:0] pts;
        logic [15:0] picture_code;
    } hdr_req_t;

    // One header byte as it leaves on the output channel.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } hdr_byte_t;

    // Classified request passed from the front end to the byte sequencer.
    typedef struct packed {
        logic [7:0]  stream_code;
        logic [15:0] pkt_len;
        logic        pts_valid;
        logic [32:0] pts;
        logic        has_pic;
        logic [15:0] picture_code;
    } hdr_desc_t;

    // Byte position counter width, enough for a 19-byte header.
    localparam int unsigned IDX_W = 5;

    // Header layout.
    localparam logic [IDX_W-1:0] BASE_LAST_IDX = 5'd8;
    localparam logic [IDX_W-1:0] FIELD_BYTES   = 5'd5;
    localparam logic [IDX_W-1:0] PTS_FIRST_IDX = 5'd9;
    localparam logic [IDX_W-1:0] PIC_FIRST_IDX = 5'd14;

    // Fixed byte values.
    localparam logic [7:0] START_CODE_END = 8'h01;
    localparam logic [7:0] HDR_FLAGS1     = 8'h80;
    localparam logic [7:0] PTS_FLAGS2     = 8'h80;
    localparam logic [7:0] PTS_HDR_LEN    = 8'h05;
    localparam logic [3:0] PTS_PREFIX     = 4'b0010;

    // Length addends: base header data, and one optional field.
    localparam logic [4:0] LEN_BASE  = 5'd3;
    localparam logic [4:0] LEN_FIELD = 5'd5;

endpackage

[rtl/core/phg_front.sv]
// Front end of the PES header generator: accepts requests and classifies them.
// Computes the packet length against the configured maximum and registers the
// result as a queue entry. Depends on phg_pkg.
module phg_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        max_len,
    input  logic               req_valid,
    output logic               req_ready,
    input  phg_pkg::hdr_req_t  req_data,
    output logic               push,
    input  logic               push_ready,
    output phg_pkg::hdr_desc_t push_data
);
    import phg_pkg::*;

    logic        vld_reg;
    logic        vld_next;
    hdr_desc_t   desc_reg;
    logic        has_pic;
    logic [4:0]  len_add;
    logic [24:0] len_sum;
    logic [15:0] pkt_len;
    logic        take;

    // The stage takes a new request when empty or when its entry moves on.
    assign req_ready = !vld_reg || push_ready;
    assign take      = req_valid && req_ready;
    assign push      = vld_reg;
    assign push_data = desc_reg;

    // Packet length: payload plus header bytes, zero when unbounded or too long.
    always_comb
    begin
        has_pic = (req_data.picture_code != 16'd0);
        len_add = LEN_BASE + (req_data.pts_valid ? LEN_FIELD : 5'd0)
                + (has_pic ? LEN_FIELD : 5'd0);
        len_sum = {1'b0, req_data.body_len} + {20'd0, len_add};
        if (req_data.body_len == 24'd0 || len_sum > {9'd0, max_len})
        begin
            pkt_len = 16'd0;
        end
        else
        begin
            pkt_len = len_sum[15:0];
        end
    end

    // Valid flag of the front register.
    always_comb
    begin
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (push_ready)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload of the front register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            desc_reg.stream_code  <= req_data.stream_code;
            desc_reg.pkt_len      <= pkt_len;
            desc_reg.pts_valid    <= req_data.pts_valid;
            desc_reg.pts          <= req_data.pts;
            desc_reg.has_pic      <= has_pic;
            desc_reg.picture_code <= req_data.picture_code;
        end
    end

    // A held entry is never overwritten before it moves on.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && !push_ready) |=> (vld_reg && $stable(desc_reg)))
        else $error("front entry changed while stalled");

    // A zero payload always yields a zero length.
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (take && req_data.body_len == 24'd0) |=> (desc_reg.pkt_len == 16'd0))
        else $error("zero payload gave nonzero length");

endmodule

[rtl/core/phg_queue.sv]
// Short queue of classified header requests between front end and sequencer.
// Register array with read and write pointers and an entry count.
// Depends on phg_pkg.
module phg_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               push_ready,
    input  phg_pkg::hdr_desc_t push_data,
    output logic               head_valid,
    input  logic               pop,
    output phg_pkg::hdr_desc_t head_data
);
    import phg_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    hdr_desc_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    // Pointer and count updates with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The count never exceeds the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // Pop is only requested when an entry is present.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

[rtl/core/phg_back.sv]
// Byte sequencer of the PES header generator: walks one queued header byte by
// byte into a registered output stage. Depends on phg_pkg.
module phg_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  phg_pkg::hdr_desc_t head_data,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_ready,
    output phg_pkg::hdr_byte_t res_data
);
    import phg_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_vld_reg;
    logic             out_vld_next;
    hdr_byte_t        out_reg;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] sub_idx;
    logic             in_pts;
    logic [7:0]       sel_byte;
    logic             is_last;
    logic             load;

    assign res_valid = out_vld_reg;
    assign res_data  = out_reg;
    assign load      = head_valid && (!out_vld_reg || res_ready);
    assign is_last   = (idx_reg == last_idx);
    assign pop       = load && is_last;

    // Last position: index 8, 13 or 18 (9, 14 or 19 bytes) depending on the optional fields.
    always_comb
    begin
        last_idx = BASE_LAST_IDX + (head_data.pts_valid ? FIELD_BYTES : '0)
                 + (head_data.has_pic ? FIELD_BYTES : '0);
    end

    // Select the byte at the current position.
    always_comb
    begin
        in_pts  = head_data.pts_valid && (idx_reg < PIC_FIRST_IDX);
        sub_idx = (idx_reg < PIC_FIRST_IDX) ? idx_reg - PTS_FIRST_IDX
                                            : idx_reg - PIC_FIRST_IDX;
        sel_byte = 8'h00;
        if (idx_reg < PTS_FIRST_IDX)
        begin
            // Fixed header part.
            case (idx_reg)
                5'd2:    sel_byte = START_CODE_END;
                5'd3:    sel_byte = head_data.stream_code;
                5'd4:    sel_byte = head_data.pkt_len[15:8];
                5'd5:    sel_byte = head_data.pkt_len[7:0];
                5'd6:    sel_byte = HDR_FLAGS1;
                5'd7:    sel_byte = head_data.pts_valid ? PTS_FLAGS2 : 8'h00;
                5'd8:    sel_byte = head_data.pts_valid ? PTS_HDR_LEN : 8'h00;
                default: sel_byte = 8'h00;
            endcase
        end
        else if (in_pts)
        begin
            // Timestamp field with prefix and marker bits.
            case (sub_idx)
                5'd0:    sel_byte = {PTS_PREFIX, head_data.pts[32:30], 1'b1};
                5'd1:    sel_byte = head_data.pts[29:22];
                5'd2:    sel_byte = {head_data.pts[21:15], 1'b1};
                5'd3:    sel_byte = head_data.pts[14:7];
                5'd4:    sel_byte = {head_data.pts[6:0], 1'b1};
                default: sel_byte = 8'h00;
            endcase
        end
        else
        begin
            // Picture start code, then the code low byte first.
            case (sub_idx)
                5'd2:    sel_byte = START_CODE_END;
                5'd3:    sel_byte = head_data.picture_code[7:0];
                5'd4:    sel_byte = head_data.picture_code[15:8];
                default: sel_byte = 8'h00;
            endcase
        end
    end

    // Position counter and output valid.
    always_comb
    begin
        idx_next     = idx_reg;
        out_vld_next = out_vld_reg;
        if (load)
        begin
            idx_next     = is_last ? '0 : idx_reg + IDX_W'(1);
            out_vld_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Output byte register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.out_byte  <= sel_byte;
            out_reg.last_byte <= is_last;
        end
    end

    // The position never runs past the longest header.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= PIC_FIRST_IDX + FIELD_BYTES - IDX_W'(1))
        else $error("byte position out of range");

    // A loaded final byte restarts the position at zero.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == '0 && out_reg.last_byte))
        else $error("position not restarted after final byte");

endmodule

[rtl/core/pes_header_generator_core.sv]
// PES header generator top level: one request in, a 9, 14 or 19 byte header out.
// An accepted request is registered in the front end, then queued; the byte
// sequencer loads its bytes into the output register, one byte per cycle while
// res_ready is high; the front end and queue take the next request meanwhile.
// Reset: rst_n clears all control state and sets max_len_reg to 65535.
module pes_header_generator_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data,
    input  logic               req_valid,
    output logic               req_ready,
    input  phg_pkg::hdr_req_t  req_data,
    output logic               res_valid,
    input  logic               res_ready,
    output phg_pkg::hdr_byte_t res_data
);
    import phg_pkg::*;

    logic [15:0] max_len_reg;
    logic        push;
    logic        push_ready;
    hdr_desc_t   push_data;
    logic        head_valid;
    logic        pop;
    hdr_desc_t   head_data;

    // Maximum packet length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= 16'hffff;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_data;
        end
    end

    // Request intake and length classification.
    phg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_len    (max_len_reg),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decoupling queue.
    phg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .head_valid (head_valid),
        .pop        (pop),
        .head_data  (head_data)
    );

    // Byte sequencer and output register.
    phg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

endmodule

[sim/pes_header_generator_core_test.sv]
// Self-checking testbench for pes_header_generator_core.
// Predicts every header byte of each accepted request and checks the byte stream.
// Depends on phg_pkg and the pes_header_generator_core RTL.
module pes_header_generator_core_test;

    import phg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // Tracks the maximum length setting and the header bytes still owed by the block.
    class hdr_byte_scoreboard;
        hdr_byte_t   owed_bytes[$];
        logic [15:0] max_len;
        int          mismatch_count;

        function new();
            max_len = 16'hffff;
            mismatch_count = 0;
        endfunction

        function void set_max_len(logic [15:0] value);
            max_len = value;
        endfunction

        function int pending();
            return owed_bytes.size();
        endfunction

        function void push_byte(logic [7:0] value);
            hdr_byte_t b;
            b.out_byte = value;
            b.last_byte = 1'b0;
            owed_bytes.push_back(b);
        endfunction

        // Works out the whole header for one accepted request.
        function void note_request(hdr_req_t r);
            logic [31:0] pkt_len;
            logic        has_pic;
            hdr_byte_t   tail;
            has_pic = (r.picture_code != 16'h0000);
            pkt_len = {8'h00, r.body_len};
            if (pkt_len != 0)
            begin
                pkt_len = pkt_len + 3 + (r.pts_valid ? 5 : 0) + (has_pic ? 5 : 0);
            end
            if (pkt_len > {16'h0000, max_len})
            begin
                pkt_len = 0;
            end

            // Fixed part: start code prefix, stream id, length, flags.
            push_byte(8'h00);
            push_byte(8'h00);
            push_byte(8'h01);
            push_byte(r.stream_code);
            push_byte(pkt_len[15:8]);
            push_byte(pkt_len[7:0]);
            push_byte(8'h80);
            push_byte(r.pts_valid ? 8'h80 : 8'h00);
            push_byte(r.pts_valid ? 8'h05 : 8'h00);

            // Timestamp split 3/15/15 with marker bits.
            if (r.pts_valid)
            begin
                push_byte({4'b0010, r.pts[32:30], 1'b1});
                push_byte(r.pts[29:22]);
                push_byte({r.pts[21:15], 1'b1});
                push_byte(r.pts[14:7]);
                push_byte({r.pts[6:0], 1'b1});
            end

            // Picture start code, low byte first.
            if (has_pic)
            begin
                push_byte(8'h00);
                push_byte(8'h00);
                push_byte(8'h01);
                push_byte(r.picture_code[7:0]);
                push_byte(r.picture_code[15:8]);
            end

            tail = owed_bytes.pop_back();
            tail.last_byte = 1'b1;
            owed_bytes.push_back(tail);
        endfunction

        task report(string msg);
            mismatch_count++;
            if (mismatch_count <= 40)
            begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
        endtask

        // Compares one accepted output byte with the oldest owed byte.
        task check_byte(hdr_byte_t got);
            hdr_byte_t want;
            if (owed_bytes.size() == 0)
            begin
                report($sformatf("byte %02h last %0b with no request pending",
                                 got.out_byte, got.last_byte));
                return;
            end
            want = owed_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
            end
            if (got.last_byte !== want.last_byte)
            begin
                report($sformatf("last_byte %0b, expected %0b", got.last_byte, want.last_byte));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = 16'h0000;
    logic        req_valid = 1'b0;
    logic        req_ready;
    hdr_req_t    req_data = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    hdr_byte_t   res_data;

    hdr_byte_scoreboard sb = new();
    int                 requests_sent = 0;

    pes_header_generator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always #4 clk = ~clk;

    // Watchdog on the total cycle count.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("pes_header_generator_core test failed");
        $finish;
    end

    function automatic hdr_req_t make_request(logic [23:0] payload, logic [7:0] sid,
                                              logic has_pts, logic [32:0] pts,
                                              logic [15:0] pic);
        hdr_req_t r;
        r.body_len = payload;
        r.stream_code = sid;
        r.pts_valid = has_pts;
        r.pts = pts;
        r.picture_code = pic;
        return r;
    endfunction

    // Random request; payload sizes lean toward the current length limit.
    function automatic hdr_req_t random_request(logic [15:0] limit);
        hdr_req_t r;
        int       sel;
        sel = $urandom_range(0, 3);
        case (sel)
            0: r.body_len = 24'($urandom);
            1: r.body_len = 24'($urandom_range(0, 64));
            2: r.body_len = (limit > 20) ? 24'(limit - $urandom_range(0, 20))
                                         : 24'($urandom_range(0, 32));
            default: r.body_len = $urandom_range(0, 1) ? 24'h000000
                                  : 24'(24'hffffff - $urandom_range(0, 15));
        endcase
        r.stream_code = 8'($urandom);
        r.pts_valid = 1'($urandom_range(0, 1));
        r.pts = {1'($urandom_range(0, 1)), 32'($urandom)};
        r.picture_code = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
        return r;
    endfunction

    // Offers one request after a random gap and waits for it to be taken.
    task send_request(hdr_req_t r);
        int gap;
        gap = (((requests_sent / 40) % 3) == 1) ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(r);
        requests_sent++;
    endtask

    // Stops offering and waits for every owed byte to arrive.
    task drain_block();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task write_max_len(logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_max_len(value);
    endtask

    task send_random(int count);
        for (int i = 0; i < count; i++)
        begin
            send_request(random_request(sb.max_len));
        end
    endtask

    // Output side: random stalls, two long hold-offs, and stall-free stretches.
    initial
    begin : drain_results
        int stall;
        int bytes_seen;
        bytes_seen = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (bytes_seen == 400 || bytes_seen == 1600)
            begin
                stall = 300;
            end
            else if (((bytes_seen / 150) % 4) == 3)
            begin
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 7);
            end
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_valid);
            sb.check_byte(res_data);
            bytes_seen++;
        end
    end

    // Main sequence: reset, directed requests, then random phases per length limit.
    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under the reset limit of 65535.
        send_request(make_request(24'd0, 8'hE0, 1'b0, 33'h0, 16'h0000));
        send_request(make_request(24'd1, 8'hC0, 1'b0, 33'h0, 16'h0000));
        send_request(make_request(24'hffffff, 8'hFF, 1'b1, 33'h1_ffff_ffff, 16'hffff));
        send_request(make_request(24'd65522, 8'h00, 1'b1, 33'h0, 16'h0001));
        send_request(make_request(24'd65523, 8'hBD, 1'b1, 33'h1_0000_0000, 16'h0100));
        send_request(make_request(24'd65532, 8'hE1, 1'b0, 33'h1_2345_6789, 16'h0000));
        send_request(make_request(24'd65533, 8'hE2, 1'b0, 33'h0, 16'h0000));
        send_request(make_request(24'd65527, 8'hC1, 1'b1, 33'h0, 16'h0000));
        send_request(make_request(24'd65528, 8'hC2, 1'b0, 33'h0, 16'h8000));
        send_request(make_request(24'h555555, 8'h55, 1'b1, 33'h1_5555_5555, 16'h5555));
        send_request(make_request(24'haaaaaa, 8'hAA, 1'b1, 33'h0_aaaa_aaaa, 16'haaaa));
        send_request(make_request(24'd100, 8'h01, 1'b1, 33'h0_4000_0000, 16'h00ff));
        send_request(make_request(24'd256, 8'h80, 1'b1, 33'h0_0000_7fff, 16'hff00));
        send_request(make_request(24'd0, 8'h7F, 1'b1, 33'h0_3fff_8000, 16'h1234));
        send_random(80);
        drain_block();

        // Limit of zero: every length is written as zero.
        write_max_len(16'h0000);
        send_request(make_request(24'd1, 8'hE0, 1'b0, 33'h0, 16'h0000));
        send_request(make_request(24'd0, 8'hE0, 1'b1, 33'h0, 16'h0001));
        send_random(40);
        drain_block();

        write_max_len(16'($urandom_range(1, 65534)));
        send_random(60);
        drain_block();

        write_max_len(16'($urandom_range(4, 40)));
        send_random(60);
        drain_block();

        write_max_len(16'hffff);
        send_random(60);
        drain_block();

        repeat (20) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
        begin
            $display("pes_header_generator_core test passed");
        end
        else
        begin
            $display("pes_header_generator_core test failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/phg_pkg.sv
rtl/core/phg_front.sv
rtl/core/phg_queue.sv
rtl/core/phg_back.sv
rtl/core/pes_header_generator_core.sv
sim/pes_header_generator_core_test.sv
